@@ src/set_assoc_lru_cache_model_defines.svh @@
// Assertion macros for the cache model.
`ifndef SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_MODEL_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define SALC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Implication checked on the edge after the antecedent.
`define SALC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

@@ src/salc_pkg.sv @@
package salc_pkg;

    localparam int MaxWays   = 8;
    localparam int MaxSets   = 512;
    localparam int AddrBits  = 32;
    localparam int WayBits   = $clog2(MaxWays);
    localparam int SetBits   = $clog2(MaxSets);
    localparam int TagBits   = AddrBits - 2;
    localparam int RowBits   = SetBits + 1;
    localparam int Rows      = 2 * MaxSets;
    localparam int DirtyBits = 13;
    localparam int ClrBits   = RowBits + 1;

    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;

    localparam logic [2:0] REG_SPLIT = 3'd0;
    localparam logic [2:0] REG_WB    = 3'd1;
    localparam logic [2:0] REG_WA    = 3'd2;
    localparam logic [2:0] REG_WAYS  = 3'd3;
    localparam logic [2:0] REG_SETS  = 3'd4;
    localparam logic [2:0] REG_BLOCK = 3'd5;

    typedef struct packed {
        logic               valid;
        logic               dirty;
        logic [WayBits-1:0] rank;
        logic [TagBits-1:0] tag;
    } line_t;

    typedef line_t [MaxWays-1:0] row_t;

endpackage

@@ src/set_assoc_lru_cache_model.sv @@
// Set-associative LRU cache model, unified or split I/D, write-back or
// write-through, write-allocate or not.
// Access channel: present command and address with start high while busy is
// low. The item is taken at that edge; busy rises for the lookup.
// The set row is read from a synchronous memory, modified and written back:
// the read state reads it, the compute state computes and writes it back.
// The result appears on hit, replaced, fetched_words, copied_back_words
// and dirty_line_count for one cycle with done high, registered after the
// read and compute states; busy is low then, so the next item may start at its edge.
// A new item is not taken until the last one has left the read and compute
// states; this follows from the read-modify-write of the single-port set memory.
// The receiver cannot stall; the outputs keep a result only until the next one.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; write
// only while idle. cfg_ready is always high.
// Reset: after rst_n rises, a clearing pass walks all 1024 set rows, one
// per cycle, with busy high; no item is taken until it finishes.
// Configuration writes are taken during the pass.
module set_assoc_lru_cache_model
    import salc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [31:0] address,
    output logic        done,
    output logic        hit,
    output logic        replaced,
    output logic [5:0]  fetched_words,
    output logic [5:0]  copied_back_words,
    output logic [12:0] dirty_line_count,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [3:0]  cfg_data
);

`include "set_assoc_lru_cache_model_defines.svh"

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_CALC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic [ClrBits-1:0] clr_reg;

    logic split_reg, wb_reg, wa_reg;
    logic [3:0] ways_reg, sib_reg;
    logic [2:0] bob_reg;

    row_t mem [Rows];
    row_t rd_data;
    logic [RowBits-1:0] row_reg;
    logic               c_reg, wr_reg, fe_reg;
    logic [TagBits-1:0] tag_reg;
    logic [3:0]         nw_reg;
    logic [5:0]         wpb_reg;
    logic [DirtyBits-1:0] dtot_reg [2];

    // address decode on acceptance
    logic [3:0] nways, sib;
    logic [2:0] bob;
    logic       acc_fetch, acc_c;
    logic [31:0] sh_set, sh_tag;
    logic [SetBits-1:0] set_idx;

    always_comb
    begin
        nways = (ways_reg == 4'd0) ? 4'd1 :
                (ways_reg > 4'(MaxWays)) ? 4'(MaxWays) : ways_reg;
        sib = (sib_reg > 4'(SetBits)) ? 4'(SetBits) : sib_reg;
        bob = (bob_reg < 3'd2) ? 3'd2 : bob_reg;
        acc_fetch = command[1];
        acc_c = split_reg && !acc_fetch;
        sh_set = address >> bob;
        set_idx = sh_set[SetBits-1:0] & SetBits'((32'd1 << sib) - 32'd1);
        sh_tag = address >> (5'(bob) + 5'(sib));
    end

    wire accept = start && (state_reg == ST_IDLE);
    assign busy = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    // compute stage
    logic hit_c, rep_c, inv_found;
    logic [WayBits-1:0] hw, iw, bw, vw;
    logic [WayBits-1:0] lim;
    row_t nrow;
    logic [5:0] fetched_c, copied_c;
    logic [DirtyBits-1:0] dt_c;

    always_comb
    begin
        hit_c = 1'b0;
        hw = '0;
        inv_found = 1'b0;
        iw = '0;
        bw = '0;
        for (int i = MaxWays - 1; i >= 0; i--)
        begin
            if (4'(i) < nw_reg)
            begin
                if (rd_data[i].valid && rd_data[i].tag == tag_reg)
                begin
                    hit_c = 1'b1;
                    hw = WayBits'(i);
                end
                if (!rd_data[i].valid)
                begin
                    inv_found = 1'b1;
                    iw = WayBits'(i);
                end
            end
        end
        for (int i = 1; i < MaxWays; i++)
        begin
            if (4'(i) < nw_reg && rd_data[i].rank > rd_data[bw].rank)
                bw = WayBits'(i);
        end
        nrow = rd_data;
        rep_c = 1'b0;
        fetched_c = '0;
        copied_c = '0;
        dt_c = dtot_reg[c_reg];
        vw = hit_c ? hw : (inv_found ? iw : bw);
        lim = hit_c ? rd_data[hw].rank : WayBits'(MaxWays - 1);
        if (hit_c || !(wr_reg && !wa_reg))
        begin
            for (int i = 0; i < MaxWays; i++)
            begin
                if (4'(i) < nw_reg && WayBits'(i) != vw && rd_data[i].valid
                    && (hit_c ? rd_data[i].rank < lim
                              : rd_data[i].rank != WayBits'(MaxWays - 1)))
                    nrow[i].rank = rd_data[i].rank + 1'b1;
            end
            nrow[vw].rank = '0;
        end
        if (hit_c)
        begin
            if (wr_reg)
            begin
                if (wb_reg)
                begin
                    if (!rd_data[hw].dirty)
                    begin
                        nrow[hw].dirty = 1'b1;
                        dt_c = dt_c + 1'b1;
                    end
                end
                else
                    copied_c = 6'd1;
            end
        end
        else if (wr_reg && !wa_reg)
            copied_c = 6'd1;
        else
        begin
            fetched_c = wpb_reg;
            if (!inv_found)
            begin
                rep_c = 1'b1;
                if (rd_data[bw].dirty)
                begin
                    copied_c = wpb_reg;
                    if (dt_c != '0)
                        dt_c = dt_c - 1'b1;
                end
            end
            nrow[vw].valid = 1'b1;
            nrow[vw].tag = tag_reg;
            nrow[vw].dirty = wr_reg && wb_reg;
            if (wr_reg)
            begin
                if (wb_reg)
                    dt_c = dt_c + 1'b1;
                else
                    copied_c = copied_c + 6'd1;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == ClrBits'(Rows - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_READ;
            ST_READ:  state_next = ST_CALC;
            ST_CALC:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg <= '0;
            split_reg <= 1'b1;
            wb_reg <= 1'b1;
            wa_reg <= 1'b1;
            ways_reg <= 4'd1;
            sib_reg <= 4'd9;
            bob_reg <= 3'd4;
            dtot_reg[0] <= '0;
            dtot_reg[1] <= '0;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done <= (state_reg == ST_CALC);
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + 1'b1;
            if (state_reg == ST_CALC)
                dtot_reg[c_reg] <= dt_c;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_SPLIT: split_reg <= cfg_data[0];
                    REG_WB:    wb_reg <= cfg_data[0];
                    REG_WA:    wa_reg <= cfg_data[0];
                    REG_WAYS:  ways_reg <= cfg_data;
                    REG_SETS:  sib_reg <= cfg_data;
                    REG_BLOCK: bob_reg <= cfg_data[2:0];
                    default:   ;
                endcase
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= {acc_c, set_idx};
            c_reg <= acc_c;
            wr_reg <= (command == CMD_WRITE);
            fe_reg <= acc_fetch;
            tag_reg <= TagBits'(sh_tag);
            nw_reg <= nways;
            wpb_reg <= 6'(6'd1 << (bob - 3'd2));
        end
        if (state_reg == ST_CALC)
        begin
            hit <= hit_c;
            replaced <= rep_c;
            fetched_words <= fetched_c;
            copied_back_words <= copied_c;
            dirty_line_count <= dt_c;
        end
    end

    // set memory: one port, read then write back
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_CLEAR)
            mem[clr_reg[RowBits-1:0]] <= '0;
        else if (state_reg == ST_CALC)
            mem[row_reg] <= nrow;
        rd_data <= mem[row_reg];
    end

    `SALC_ASSERT_NEXT(a_done_after_calc, state_reg == ST_CALC, done)
    `SALC_ASSERT_IMP(a_done_one_cycle, done, !$past(done))
    `SALC_ASSERT_IMP(a_no_accept_busy, state_reg == ST_READ || state_reg == ST_CALC, busy)
    `SALC_ASSERT_IMP(a_fill_counts, done && !hit && fetched_words != 6'd0,
                     fetched_words <= 6'd32)
    `SALC_ASSERT_IMP(a_rep_miss, done && replaced, !hit && !$past(fe_reg && wr_reg))

endmodule

@@ tb/set_assoc_lru_cache_model_test.sv @@
module set_assoc_lru_cache_model_test;
    import salc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_FETCH = 2'd2;
    localparam int LineCount = 2 * MaxSets * MaxWays;
    localparam int CycleLimit = 400000;

    typedef struct packed {
        logic        hit;
        logic        replaced;
        logic [5:0]  fetched;
        logic [5:0]  copied;
        logic [12:0] dirty;
    } access_result_t;

    class cache_scoreboard;
        logic [29:0] tags [LineCount];
        bit          valid_q [LineCount];
        bit          dirty_q [LineCount];
        int          rank_q [LineCount];
        int          dirty_total [2];
        bit          split_on, wback_on, walloc_on;
        int          ways_cfg, sets_cfg, block_cfg;
        access_result_t pending [$];
        int          mismatches;

        function new();
            for (int i = 0; i < LineCount; i++)
            begin
                valid_q[i] = 0;
                dirty_q[i] = 0;
                rank_q[i] = 0;
                tags[i] = '0;
            end
            dirty_total[0] = 0;
            dirty_total[1] = 0;
            split_on = 1;
            wback_on = 1;
            walloc_on = 1;
            ways_cfg = 1;
            sets_cfg = 9;
            block_cfg = 4;
            mismatches = 0;
        endfunction

        function void set_register(logic [2:0] idx, logic [3:0] data);
            case (idx)
                REG_SPLIT: split_on = data[0];
                REG_WB:    wback_on = data[0];
                REG_WA:    walloc_on = data[0];
                REG_WAYS:  ways_cfg = int'(data);
                REG_SETS:  sets_cfg = int'(data);
                REG_BLOCK: block_cfg = int'(data[2:0]);
                default: ;
            endcase
        endfunction

        function void age_ways(int base, int ways, int keep, int lim);
            for (int i = 0; i < ways; i++)
                if (i != keep && valid_q[base+i] && rank_q[base+i] < lim
                    && rank_q[base+i] < MaxWays - 1)
                    rank_q[base+i]++;
        endfunction

        function void note_access(logic [1:0] cmd, logic [31:0] addr);
            access_result_t r;
            bit is_wr, is_if;
            int c, ways, sib, bob, wpb, set_i, base, w, best, k;
            logic [31:0] tag;
            is_wr = (cmd == CMD_WRITE);
            is_if = (cmd >= CMD_FETCH);
            c = (split_on && !is_if) ? 1 : 0;
            ways = ways_cfg < 1 ? 1 : (ways_cfg > MaxWays ? MaxWays : ways_cfg);
            sib = sets_cfg;
            while (sib > 0 && (1 << sib) > MaxSets)
                sib--;
            bob = block_cfg < 2 ? 2 : block_cfg;
            wpb = 1 << (bob - 2);
            set_i = (addr >> bob) & ((1 << sib) - 1);
            tag = addr >> (bob + sib);
            base = (c * MaxSets + set_i) * MaxWays;
            r = '0;
            w = ways;
            for (int i = 0; i < ways; i++)
                if (valid_q[base+i] && tags[base+i] == tag[29:0])
                begin
                    w = i;
                    break;
                end
            if (w < ways)
            begin
                k = base + w;
                r.hit = 1'b1;
                age_ways(base, ways, w, rank_q[k]);
                rank_q[k] = 0;
                if (is_wr)
                begin
                    if (wback_on)
                    begin
                        if (!dirty_q[k])
                        begin
                            dirty_q[k] = 1;
                            dirty_total[c]++;
                        end
                    end
                    else
                        r.copied = 6'd1;
                end
            end
            else if (is_wr && !walloc_on)
                r.copied = 6'd1;
            else
            begin
                r.fetched = 6'(wpb);
                w = ways;
                for (int i = 0; i < ways; i++)
                    if (!valid_q[base+i])
                    begin
                        w = i;
                        break;
                    end
                if (w == ways)
                begin
                    best = 0;
                    for (int i = 1; i < ways; i++)
                        if (rank_q[base+i] > rank_q[base+best])
                            best = i;
                    w = best;
                    k = base + w;
                    r.replaced = 1'b1;
                    if (dirty_q[k])
                    begin
                        r.copied = 6'(r.copied + wpb);
                        if (dirty_total[c] > 0)
                            dirty_total[c]--;
                        dirty_q[k] = 0;
                    end
                end
                k = base + w;
                age_ways(base, ways, w, MaxWays);
                valid_q[k] = 1;
                tags[k] = tag[29:0];
                rank_q[k] = 0;
                dirty_q[k] = 0;
                if (is_wr)
                begin
                    if (wback_on)
                    begin
                        dirty_q[k] = 1;
                        dirty_total[c]++;
                    end
                    else
                        r.copied = r.copied + 6'd1;
                end
            end
            r.dirty = 13'(dirty_total[c]);
            pending.push_back(r);
        endfunction

        function void check_result(access_result_t got);
            access_result_t exp_r;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, actual %p", exp_r, got);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [31:0] address;
    logic        done;
    logic        hit;
    logic        replaced;
    logic [5:0]  fetched_words;
    logic [5:0]  copied_back_words;
    logic [12:0] dirty_line_count;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [3:0]  cfg_data;

    cache_scoreboard sb;
    int cycles;
    logic [31:0] addr_pool [8];

    set_assoc_lru_cache_model u_top (.*);

    initial
    begin
        clk = 0;
        forever
        begin
            #4 clk = 1;
            #4 clk = 0;
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            sb.check_result({hit, replaced, fetched_words, copied_back_words,
                dirty_line_count});

    // hold valid high across back-to-back writes; configure drops it
    task automatic write_reg(logic [2:0] idx, logic [3:0] data);
        cfg_valid <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_register(idx, data);
    endtask

    // hold start until accepted, then drop unless next item follows at once
    task automatic send_access(logic [1:0] cmd, logic [31:0] addr, bit keep);
        start <= 1;
        command <= cmd;
        address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_access(cmd, addr);
        if (!keep)
        begin
            start <= 0;
            @(posedge clk);
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_addr();
        logic [31:0] a;
        if ($urandom_range(0, 9) < 7)
        begin
            a = addr_pool[$urandom_range(0, 7)];
            // sometimes vary bits 0-3 and 8-11, keeping tags clashing when they are set and offset bits
            if ($urandom_range(0, 1))
                a = a ^ ($urandom & 32'h0000_0F0F);
        end
        else
            a = $urandom;
        return a;
    endfunction

    task automatic random_phase(int count);
        int left, burst;
        left = count;
        while (left > 0)
        begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && left > 0)
            begin
                send_access(2'($urandom_range(0, 3)), pick_addr(),
                    burst > 1 && left > 1);
                burst--;
                left--;
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 6))
                    @(posedge clk);
        end
    endtask

    task automatic configure(bit sp, bit wb, bit wa, int ways, int sets, int blk);
        write_reg(REG_SPLIT, 4'(sp));
        write_reg(REG_WB, 4'(wb));
        write_reg(REG_WA, 4'(wa));
        write_reg(REG_WAYS, 4'(ways));
        write_reg(REG_SETS, 4'(sets));
        write_reg(REG_BLOCK, 4'(blk));
        cfg_valid <= 0;
    endtask

    initial
    begin
        sb = new();
        cycles = 0;
        rst_n = 0;
        start = 0;
        command = '0;
        address = '0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        for (int i = 0; i < 8; i++)
            addr_pool[i] = $urandom;
        repeat (12)
            @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, all commands, odd register values
        configure(1, 1, 1, 2, 0, 2);
        send_access(CMD_READ, 32'h0000_0000, 0);
        send_access(CMD_WRITE, 32'h0000_0000, 0);
        send_access(CMD_FETCH, 32'hFFFF_FFFF, 0);
        send_access(2'd3, 32'hFFFF_FFFC, 0);
        send_access(CMD_WRITE, 32'h0000_0004, 1);
        send_access(CMD_WRITE, 32'h0000_0008, 1);
        send_access(CMD_READ, 32'hFFFF_FFFF, 0);
        drain();
        configure(0, 0, 0, 0, 15, 0);
        send_access(CMD_WRITE, 32'h1234_5678, 0);
        send_access(CMD_READ, 32'h1234_5678, 0);
        send_access(CMD_WRITE, 32'h1234_5678, 0);
        send_access(CMD_WRITE, 32'hAAAA_5555, 0);
        drain();
        configure(1, 1, 0, 15, 9, 7);
        send_access(CMD_WRITE, 32'h5555_AAAA, 0);
        send_access(CMD_READ, 32'h5555_AAAA, 0);
        send_access(CMD_WRITE, 32'h5555_AAAA, 0);
        send_access(CMD_FETCH, 32'h8000_0000, 0);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            configure($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                ph == 0 ? 8 : (ph == 1 ? 1 : $urandom_range(0, 15)),
                ph == 0 ? 9 : (ph == 1 ? 0 : $urandom_range(0, 15)),
                ph == 0 ? 7 : (ph == 1 ? 2 : $urandom_range(0, 7)));
            for (int i = 0; i < 8; i++)
                addr_pool[i] = $urandom;
            random_phase(60);
            drain();
            random_phase(60);
            drain();
        end

        drain();
        repeat (10)
            @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

@@ set_assoc_lru_cache_model.f @@
+incdir+src
src/salc_pkg.sv
src/set_assoc_lru_cache_model.sv
tb/set_assoc_lru_cache_model_test.sv
